// ===== rtl/dts_pkg.sv =====
// shared types and constants for the deadline timer scheduler
package dts_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int SCAN_W     = $clog2(NUM_TIMERS + 1);

  localparam int OP_W    = 3;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;
  localparam int TIME_W  = 48;
  localparam int DL_W    = 49;
  localparam int WAIT_W  = 32;
  localparam int KIND_W  = 2;
  localparam int ACT_W   = 5;

  localparam logic [WAIT_W-1:0] WAIT_MAX  = 32'h7FFF_FFFF;
  localparam logic [WAIT_W-1:0] WAIT_NONE = 32'hFFFF_FFFF;

  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_REPEAT = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_RUN    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  typedef enum logic [1:0] {
    TS_IDLE    = 2'd0,
    TS_ACTIVE  = 2'd1,
    TS_STOPPED = 2'd2
  } tstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_REPORT
  } state_t;

endpackage

// ===== rtl/deadline_timer_scheduler_core.sv =====
// timer bank with deadline memory, run scan and result register
//
//  channel  dir  handshake         payload
//  s_       in   s_tvalid/tready   s_tuser opcode, s_tdata timer_id/delay_ms/current_time
//  m_       out  m_tvalid/tready   m_tuser result_kind, m_tdata fired_id/wait_ms/active_timers,
//                                  m_tlast
//
// start, repeat, stop, clear and unused opcodes: ack loaded at accept
// run: one scan of the deadline/period memories per fired timer (one read per
//   cycle, last compare, decide, fire), and the same again for the final scan
//   and the report
// reset clears status, period-valid bits and control; no memory clearing pass
// a stalled result holds the datapath in the fire or report state
module deadline_timer_scheduler_core
  import dts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // opcode
  input  logic [87:0] s_tdata,   // timer_id, delay_ms, current_time, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // result_kind
  output logic [47:0] m_tdata,   // fired_id, wait_ms, active_timers, zero pad
  output logic        m_tlast
);

  state_t state, state_next;

  // unpacked input fields
  logic [OP_W-1:0]    in_op;
  logic [ID_W-1:0]    in_id;
  logic [DELAY_W-1:0] in_delay;
  logic [TIME_W-1:0]  in_now;

  assign in_op    = s_tuser;
  assign in_id    = s_tdata[3:0];
  assign in_delay = s_tdata[35:4];
  assign in_now   = s_tdata[83:36];

  // timer state
  logic [DL_W-1:0]    dl_mem  [NUM_TIMERS];
  logic [DELAY_W-1:0] per_mem [NUM_TIMERS];
  tstat_t             status  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] per_valid;
  logic [NUM_TIMERS-1:0] act_vec;
  logic [CNT_W-1:0]   active_count;

  // scan state
  logic [TIME_W-1:0]  now;
  logic [SCAN_W-1:0]  cnt;
  logic               rd_v;
  logic [IDX_W-1:0]   rd_idx;
  logic [DL_W-1:0]    dl_q;
  logic [DELAY_W-1:0] per_q;
  logic               best_v;
  logic [IDX_W-1:0]   best_idx;
  logic [DL_W-1:0]    best_dl;
  logic [DELAY_W-1:0] best_per;

  // output register
  logic [KIND_W-1:0] out_kind;
  logic [ID_W-1:0]   out_id;
  logic [WAIT_W-1:0] out_wait;
  logic [ACT_W-1:0]  out_act;

  // control strobes
  logic out_free;
  logic in_xfer;
  logic load_ack;
  logic load_fire;
  logic load_report;
  logic scan_issue;

  logic [IDX_W-1:0] id_idx;
  logic             id_ok;
  logic             due;
  logic             rearm;
  logic [DL_W-1:0]  diff;
  logic [WAIT_W-1:0] wait_val;
  logic [CNT_W-1:0] count_ctl;
  logic             dl_we;
  logic [IDX_W-1:0] dl_waddr;
  logic [DL_W-1:0]  dl_wdata;

  assign out_free = !m_tvalid || m_tready;
  assign id_idx   = IDX_W'(in_id);
  assign id_ok    = 32'(in_id) < NUM_TIMERS;
  assign due      = best_v && (best_dl <= {1'b0, now});
  assign rearm    = best_per != '0;
  assign diff     = best_dl - {1'b0, now};

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      act_vec[i] = status[i] == TS_ACTIVE;
    end
  end

  always_comb begin
    if (!best_v) begin
      wait_val = WAIT_NONE;
    end else if (diff >= DL_W'(WAIT_MAX)) begin
      wait_val = WAIT_MAX;
    end else begin
      wait_val = diff[WAIT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_RUN) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == SCAN_W'(NUM_TIMERS)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = due ? ST_FIRE : ST_REPORT;
      end
      ST_FIRE: begin
        if (out_free) state_next = ST_SCAN;
      end
      ST_REPORT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready    = 1'b0;
    load_fire   = 1'b0;
    load_report = 1'b0;
    scan_issue  = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready    = out_free;
      ST_SCAN:   scan_issue  = cnt < SCAN_W'(NUM_TIMERS);
      ST_DECIDE: ;
      ST_FIRE:   load_fire   = out_free;
      ST_REPORT: load_report = out_free;
      default:   ;
    endcase
  end

  assign in_xfer  = s_tvalid && s_tready;
  assign load_ack = in_xfer && in_op != OP_RUN;

  // active count after a control operation
  always_comb begin
    count_ctl = active_count;
    if (id_ok) begin
      unique case (in_op) inside
        OP_START, OP_REPEAT: begin
          if (status[id_idx] != TS_ACTIVE) count_ctl = active_count + 1'b1;
        end
        OP_STOP, OP_CLEAR: begin
          if (status[id_idx] == TS_ACTIVE) count_ctl = active_count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // deadline write port: control arm or re-arm after firing
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = id_idx;
    dl_wdata = DL_W'(in_now) + DL_W'(in_delay);
    if (load_fire) begin
      dl_we    = rearm;
      dl_waddr = best_idx;
      dl_wdata = DL_W'(now) + DL_W'(best_per);
    end else if (in_xfer && id_ok && (in_op == OP_START || in_op == OP_REPEAT)) begin
      dl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (in_xfer && id_ok && in_op == OP_REPEAT) begin
      per_mem[id_idx] <= in_delay;
    end
    if (scan_issue) begin
      dl_q  <= dl_mem[cnt[IDX_W-1:0]];
      per_q <= per_mem[cnt[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_count <= '0;
      per_valid    <= '0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
      rd_v         <= 1'b0;
      best_v       <= 1'b0;
      cnt          <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status[i] <= TS_IDLE;
      end
    end else begin
      state <= state_next;
      if (load_ack || load_fire || load_report) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (in_xfer) begin
        if (in_op == OP_RUN) begin
          now    <= in_now;
          cnt    <= '0;
          best_v <= 1'b0;
        end else begin
          active_count <= count_ctl;
          if (id_ok) begin
            case (in_op) inside
              OP_START:  status[id_idx] <= TS_ACTIVE;
              OP_REPEAT: begin
                status[id_idx]    <= TS_ACTIVE;
                per_valid[id_idx] <= 1'b1;
              end
              OP_STOP: begin
                if (status[id_idx] == TS_ACTIVE) status[id_idx] <= TS_STOPPED;
              end
              OP_CLEAR: begin
                status[id_idx]    <= TS_IDLE;
                per_valid[id_idx] <= 1'b0;
              end
              default: ;
            endcase
          end
          m_tlast  <= 1'b1;
          out_kind <= KIND_ACK;
          out_id   <= in_id;
          out_wait <= '0;
          out_act  <= ACT_W'(count_ctl);
        end
      end

      // one read issued per cycle, compared in the next cycle
      rd_v <= scan_issue;
      if (scan_issue) begin
        rd_idx <= cnt[IDX_W-1:0];
        cnt    <= cnt + 1'b1;
      end
      if (rd_v && act_vec[rd_idx] && (!best_v || dl_q < best_dl)) begin
        best_v   <= 1'b1;
        best_idx <= rd_idx;
        best_dl  <= dl_q;
        best_per <= per_valid[rd_idx] ? per_q : '0;
      end

      if (load_fire) begin
        status[best_idx] <= rearm ? TS_ACTIVE : TS_STOPPED;
        if (!rearm) active_count <= active_count - 1'b1;
        cnt      <= '0;
        best_v   <= 1'b0;
        m_tlast  <= 1'b0;
        out_kind <= KIND_FIRED;
        out_id   <= ID_W'(best_idx);
        out_wait <= '0;
        out_act  <= rearm ? ACT_W'(active_count) : ACT_W'(active_count - 1'b1);
      end

      if (load_report) begin
        m_tlast  <= 1'b1;
        out_kind <= KIND_REPORT;
        out_id   <= '0;
        out_wait <= wait_val;
        out_act  <= ACT_W'(active_count);
      end
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {7'd0, out_act, out_wait, out_id};

`ifndef SYNTH
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(active_count) == $countones(act_vec))
    else $error("active count does not match status bank");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_scan_last_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == SCAN_W'(NUM_TIMERS)) |-> rd_v)
    else $error("scan ended without last read data");

  a_fire_rescan: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> state == ST_SCAN && cnt == '0 && !best_v)
    else $error("fire did not restart the scan");

  a_fire_due: assert property (@(posedge clk) disable iff (rst)
    load_fire |-> due && act_vec[best_idx])
    else $error("fired a timer that is not due");
`endif

endmodule
